@@ design/rsc_pkg.sv @@
// shared types, constants and helpers of the ray segment compositor
package rsc_pkg;

  // default sizes
  localparam int RSC_TABLE_SIZE     = 1024;
  localparam int RSC_MAX_COMPONENTS = 4;
  localparam int LANES_HW           = 4;

  // field widths
  localparam int REQ_W     = 2;
  localparam int COMP_W    = 2;
  localparam int INDEX_W   = 10;
  localparam int LEN_W     = 24;
  localparam int VALUE_W   = 32;
  localparam int COLOR_W   = 16;
  localparam int ATTEN_W   = 24;
  localparam int TAU_W     = 26;
  localparam int XP_W      = LEN_W + TAU_W + 1;
  localparam int X_W       = XP_W - 16;
  localparam int E_W       = 33;

  // stream and configuration port widths
  localparam int IN_DATA_W  = 168;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // tdata field offsets
  localparam int OFS_LEN   = 0;
  localparam int OFS_V0    = 24;
  localparam int OFS_COMP  = 152;
  localparam int OFS_INDEX = 154;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_SEGMENT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TABLE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MAP     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INDEPENDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_CH     = 2'd2;

  // exp series constants, terms of exp(-1) in Q32.32, exp(-1) itself in Q0.32
  localparam int EXP_TERMS = 12;
  localparam logic [X_W-1:0] EXP_LIMIT = X_W'(12 * 65536);
  localparam logic [63:0] EXP_T0  = 64'd4294967296;
  localparam logic [63:0] EXP_T1  = EXP_T0 / 1;
  localparam logic [63:0] EXP_T2  = EXP_T1 / 2;
  localparam logic [63:0] EXP_T3  = EXP_T2 / 3;
  localparam logic [63:0] EXP_T4  = EXP_T3 / 4;
  localparam logic [63:0] EXP_T5  = EXP_T4 / 5;
  localparam logic [63:0] EXP_T6  = EXP_T5 / 6;
  localparam logic [63:0] EXP_T7  = EXP_T6 / 7;
  localparam logic [63:0] EXP_T8  = EXP_T7 / 8;
  localparam logic [63:0] EXP_T9  = EXP_T8 / 9;
  localparam logic [63:0] EXP_T10 = EXP_T9 / 10;
  localparam logic [63:0] EXP_T11 = EXP_T10 / 11;
  localparam logic [63:0] EXP_T12 = EXP_T11 / 12;
  localparam logic [63:0] EXP_POS = EXP_T0 + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
                                  + EXP_T10 + EXP_T12;
  localparam logic [63:0] EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
                                  + EXP_T11;
  localparam logic [31:0] EXP_E1  = 32'(EXP_POS - EXP_NEG);

  // one table entry as read by a lane
  typedef struct packed {
    logic [ATTEN_W-1:0] att;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } lane_data_t;

  // accepted request as seen by the lanes
  typedef struct packed {
    logic                               accept;
    logic [REQ_W-1:0]                   req_type;
    logic [COMP_W-1:0]                  comp;
    logic [INDEX_W-1:0]                 index;
    logic [LANES_HW-1:0][VALUE_W-1:0]   value;
  } lane_req_t;

  // merge start control
  typedef struct packed {
    logic              start;
    logic [COMP_W-1:0] steps;
  } merge_ctrl_t;

  // clamp a signed word to a Q0.16 color
  function automatic logic [COLOR_W-1:0] clamp_color(input logic [VALUE_W-1:0] v);
    logic [COLOR_W-1:0] r;
    if (v[VALUE_W-1]) r = '0;
    else if (v[VALUE_W-2:COLOR_W] != '0) r = '1;
    else r = v[COLOR_W-1:0];
    return r;
  endfunction

  // clamp a signed word to a Q8.16 attenuation
  function automatic logic [ATTEN_W-1:0] clamp_atten(input logic [VALUE_W-1:0] v);
    logic [ATTEN_W-1:0] r;
    if (v[VALUE_W-1]) r = '0;
    else if (v[VALUE_W-2:ATTEN_W] != '0) r = '1;
    else r = v[ATTEN_W-1:0];
    return r;
  endfunction

endpackage

@@ design/rsc_lane.sv @@
// one component lane: scalar to index mapping and its color/attenuation table
module rsc_lane import rsc_pkg::*; #(
  parameter int TABLE_SIZE = RSC_TABLE_SIZE,
  parameter int LANE_ID    = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_req_t  req_i,
  output lane_data_t data_o
);

  localparam int AW = $clog2(TABLE_SIZE);

  logic signed [VALUE_W-1:0]   scale_q, shift_q;
  logic signed [2*VALUE_W-1:0] prod_q;
  logic signed [2*VALUE_W-1:0] shift_ext, sum;
  logic [AW-1:0]               idx_q;
  lane_data_t                  mem [TABLE_SIZE];
  lane_data_t                  rdata_q;
  logic                        mine, seg_en, map_wr, tab_wr;
  logic [VALUE_W-1:0]          my_value;

  // request decode for this lane
  assign mine     = req_i.accept && (req_i.comp == COMP_W'(LANE_ID));
  assign seg_en   = req_i.accept && (req_i.req_type == REQ_SEGMENT);
  assign map_wr   = mine && (req_i.req_type == REQ_MAP);
  assign tab_wr   = mine && (req_i.req_type == REQ_TABLE)
                    && (32'(req_i.index) < TABLE_SIZE);
  assign my_value = req_i.value[LANE_ID];

  // mapping registers
  always_ff @(posedge clk_i) begin
    if (map_wr) begin
      scale_q <= $signed(req_i.value[0]);
      shift_q <= $signed(req_i.value[1]);
    end
  end

  // scale times scalar
  always_ff @(posedge clk_i) begin
    if (seg_en) begin
      prod_q <= scale_q * $signed(my_value);
    end
  end

  // add shift and clamp to the table range
  assign shift_ext = {{VALUE_W{shift_q[VALUE_W-1]}}, shift_q};
  assign sum       = prod_q + (shift_ext <<< 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (sum[2*VALUE_W-1]) begin
      idx_q <= '0;
    end else if ({1'b0, sum[2*VALUE_W-2:VALUE_W]} >= 32'(TABLE_SIZE)) begin
      idx_q <= AW'(TABLE_SIZE - 1);
    end else begin
      idx_q <= sum[VALUE_W +: AW];
    end
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (tab_wr) begin
      mem[AW'(req_i.index)] <= '{att:   clamp_atten(req_i.value[3]),
                                 blue:  clamp_color(req_i.value[2]),
                                 green: clamp_color(req_i.value[1]),
                                 red:   clamp_color(req_i.value[0])};
    end
    rdata_q <= mem[idx_q];
  end

  assign data_o = rdata_q;

endmodule

@@ design/rsc_merge.sv @@
// merging stage: attenuation weighted mix of the lane colors, one component at a time
module rsc_merge import rsc_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  merge_ctrl_t                      ctrl_i,
  input  logic [2:0][COLOR_W-1:0]          init_col_i,
  input  logic [TAU_W-1:0]                 init_tau_i,
  input  lane_data_t [LANES_HW-1:0]        lane_i,
  output logic                             busy_o,
  output logic [2:0][COLOR_W-1:0]          col_o,
  output logic [TAU_W-1:0]                 tau_o
);

  localparam int PROD_W = COLOR_W + TAU_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int CNT_W  = $clog2(COLOR_W);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_CHECK = 3'd1;
  localparam logic [2:0] M_MUL   = 3'd2;
  localparam logic [2:0] M_ADD   = 3'd3;
  localparam logic [2:0] M_DIV   = 3'd4;

  logic [2:0]                     state_q;
  logic [COMP_W:0]                k_q;
  logic [COMP_W-1:0]              steps_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [2:0][COLOR_W-1:0]        col_q, ck_q, nq_q, nq_n;
  logic [TAU_W-1:0]               tau_q, s_q, s_sum;
  logic [ATTEN_W-1:0]             att_q;
  logic [2:0][PROD_W-1:0]         pa_q, pb_q;
  logic [2:0][TAU_W-1:0]          rem_q, rem_n;
  logic [2:0][NUM_W-1:0]          num;
  logic [2:0][TAU_W:0]            r2;
  lane_data_t                     sel;

  assign sel   = lane_i[k_q[COMP_W-1:0]];
  assign s_sum = tau_q + TAU_W'(sel.att);

  // numerator with rounding and one restoring divide step per channel
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      num[j]   = NUM_W'(pa_q[j]) + NUM_W'(pb_q[j]) + NUM_W'(s_q >> 1);
      r2[j]    = {rem_q[j], nq_q[j][COLOR_W-1]};
      nq_n[j]  = {nq_q[j][COLOR_W-2:0], (r2[j] >= {1'b0, s_q})};
      rem_n[j] = (r2[j] >= {1'b0, s_q}) ? TAU_W'(r2[j] - {1'b0, s_q}) : r2[j][TAU_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      k_q     <= '0;
      cnt_q   <= '0;
      steps_q <= '0;
    end else begin
      case (state_q)
        M_IDLE: begin
          if (ctrl_i.start) begin
            k_q     <= (COMP_W+1)'(1);
            steps_q <= ctrl_i.steps;
            state_q <= M_CHECK;
          end
        end
        M_CHECK: begin
          if (k_q > {1'b0, steps_q}) begin
            state_q <= M_IDLE;
          end else if (s_sum == '0) begin
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= M_MUL;
          end
        end
        M_MUL: state_q <= M_ADD;
        M_ADD: begin
          cnt_q   <= '0;
          state_q <= M_DIV;
        end
        M_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(COLOR_W - 1)) begin
            k_q     <= k_q + 1'b1;
            state_q <= M_CHECK;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        if (ctrl_i.start) begin
          col_q <= init_col_i;
          tau_q <= init_tau_i;
        end
      end
      M_CHECK: begin
        s_q   <= s_sum;
        att_q <= sel.att;
        ck_q  <= {sel.blue, sel.green, sel.red};
      end
      M_MUL: begin
        for (int j = 0; j < 3; j++) begin
          pa_q[j] <= PROD_W'(col_q[j] * tau_q);
          pb_q[j] <= PROD_W'(ck_q[j] * att_q);
        end
      end
      M_ADD: begin
        for (int j = 0; j < 3; j++) begin
          rem_q[j] <= num[j][COLOR_W +: TAU_W];
          nq_q[j]  <= num[j][COLOR_W-1:0];
        end
      end
      M_DIV: begin
        rem_q <= rem_n;
        nq_q  <= nq_n;
        if (cnt_q == CNT_W'(COLOR_W - 1)) begin
          col_q <= nq_n;
          tau_q <= s_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != M_IDLE);
  assign col_o  = col_q;
  assign tau_o  = tau_q;

endmodule

@@ design/rsc_exp.sv @@
// exp(-x) unit: truncated taylor series on the fraction, then powers of exp(-1)
module rsc_exp import rsc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [X_W-1:0] x_i,
  output logic           busy_o,
  output logic [E_W-1:0] e_o
);

  localparam int F_W      = 16;
  localparam int K_W      = 4;
  localparam int N_W      = 4;
  localparam int DIV_BITS = 8;
  localparam int DIV_CYC  = 5;
  localparam int DIVR_W   = DIV_BITS * DIV_CYC;
  localparam int ACC_W    = E_W + 1;
  localparam int TP_W     = E_W + F_W;
  localparam int PW_W     = E_W + 32;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MUL  = 3'd1;
  localparam logic [2:0] E_DIV  = 3'd2;
  localparam logic [2:0] E_SUB  = 3'd3;
  localparam logic [2:0] E_POW  = 3'd4;

  logic [2:0]        state_q;
  logic [K_W-1:0]    k_q, rem_q, r_n;
  logic [N_W-1:0]    n_q;
  logic [2:0]        cnt_q;
  logic [F_W-1:0]    f_q;
  logic [E_W-1:0]    t_q, e_q, t_n;
  logic [ACC_W-1:0]  pos_q, neg_q;
  logic [DIVR_W-1:0] p_q, p_n;
  logic [TP_W-1:0]   tprod;
  logic [PW_W-1:0]   pw;
  logic [K_W:0]      r5;

  // eight restoring steps of the divide by the term number
  always_comb begin
    p_n = p_q;
    r_n = rem_q;
    r5  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      r5  = {r_n, p_n[DIVR_W-1]};
      p_n = {p_n[DIVR_W-2:0], 1'b0};
      if (r5 >= {1'b0, k_q}) begin
        r5     = r5 - {1'b0, k_q};
        p_n[0] = 1'b1;
      end
      r_n = r5[K_W-1:0];
    end
  end

  assign t_n   = p_n[E_W-1:0];
  assign tprod = TP_W'(t_q) * TP_W'(f_q);
  assign pw    = PW_W'(e_q) * PW_W'(EXP_E1) + PW_W'(33'h080000000);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      k_q     <= '0;
      n_q     <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        E_IDLE: begin
          if (start_i && (x_i < EXP_LIMIT)) begin
            k_q     <= K_W'(1);
            n_q     <= x_i[F_W +: N_W];
            state_q <= E_MUL;
          end
        end
        E_MUL: begin
          cnt_q   <= '0;
          state_q <= E_DIV;
        end
        E_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'(DIV_CYC - 1)) begin
            if (k_q == K_W'(EXP_TERMS)) begin
              state_q <= E_SUB;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= E_MUL;
            end
          end
        end
        E_SUB: state_q <= E_POW;
        E_POW: begin
          if (n_q == '0) begin
            state_q <= E_IDLE;
          end else begin
            n_q <= n_q - 1'b1;
          end
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        if (start_i) begin
          if (x_i >= EXP_LIMIT) begin
            e_q <= '0;
          end else begin
            t_q   <= E_W'(EXP_T0);
            pos_q <= ACC_W'(EXP_T0);
            neg_q <= '0;
            f_q   <= x_i[F_W-1:0];
          end
        end
      end
      E_MUL: begin
        p_q   <= DIVR_W'(tprod[TP_W-1:F_W]);
        rem_q <= '0;
      end
      E_DIV: begin
        p_q   <= p_n;
        rem_q <= r_n;
        if (cnt_q == 3'(DIV_CYC - 1)) begin
          t_q <= t_n;
          if (k_q[0]) neg_q <= neg_q + ACC_W'(t_n);
          else pos_q <= pos_q + ACC_W'(t_n);
        end
      end
      E_SUB: begin
        e_q <= (pos_q >= neg_q) ? E_W'(pos_q - neg_q) : '0;
      end
      E_POW: begin
        if (n_q != '0) e_q <= pw[PW_W-1:32];
      end
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != E_IDLE);
  assign e_o    = e_q;

endmodule

@@ design/ray_segment_compositor_top.sv @@
// top level of the ray segment compositor: stream ports, sequencing and compositing
//
// Composites one ray front to back, one cell segment per input transfer. Table
// and mapping writes return nothing. A segment passes the component lanes
// (scale multiply, index clamp, table read), then the merging divider for each
// component past the first, then the exp unit: 12 series terms, then one
// multiply by exp(-1) for each whole unit of length*attenuation, or no work at
// all when that product reaches 12. One result is held in the output register
// while the next transfer is already being worked on. Tables need no clearing.
module ray_segment_compositor_top import rsc_pkg::*; #(
  parameter int TABLE_SIZE     = RSC_TABLE_SIZE,
  parameter int MAX_COMPONENTS = RSC_MAX_COMPONENTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: seg_length, value_0, value_1, value_2, value_3, entry_component,
  //        entry_index, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type, ray_start
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: red, green, blue, opacity
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_IDX   = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_MERGE = 4'd3;
  localparam logic [3:0] ST_MWAIT = 4'd4;
  localparam logic [3:0] ST_XMUL  = 4'd5;
  localparam logic [3:0] ST_EXP   = 4'd6;
  localparam logic [3:0] ST_EWAIT = 4'd7;
  localparam logic [3:0] ST_ALPHA = 4'd8;
  localparam logic [3:0] ST_WMUL  = 4'd9;
  localparam logic [3:0] ST_CMUL  = 4'd10;
  localparam logic [3:0] ST_FIN   = 4'd11;

  localparam int A_W  = COLOR_W + 1;
  localparam int W_W  = 2 * A_W;
  localparam int CW_W = COLOR_W + W_W;

  logic [3:0]                 state_q;
  logic                       indep_q, four_q;
  logic [2:0]                 count_q;
  logic [LEN_W-1:0]           len_q;
  logic                       ray_q;
  logic [2:0][COLOR_W-1:0]    dcol_q;
  logic [ATTEN_W-1:0]         dtau_q;
  logic [X_W-1:0]             x_q;
  logic [A_W-1:0]             alpha_q;
  logic [W_W-1:0]             w_q;
  logic [2:0][CW_W-1:0]       cw_q;
  logic [3:0][COLOR_W-1:0]    acc_q, base, acc_n;
  logic [OUT_DATA_W-1:0]      out_q;
  logic                       m_valid_q;

  logic                       in_acc, seg_acc, out_free;
  lane_req_t                  req;
  lane_data_t [LANES_HW-1:0]  lane_data;
  merge_ctrl_t                mctrl;
  logic [2:0][COLOR_W-1:0]    init_col, mcol;
  logic [TAU_W-1:0]           init_tau, mtau;
  logic                       merge_busy, exp_busy;
  logic [E_W-1:0]             exp_e;
  logic [2:0]                 n_eff;
  logic [XP_W-1:0]            xprod;
  logic [E_W:0]               e_rnd;
  logic [CW_W:0]              c_rnd;
  logic [W_W:0]               o_rnd;
  logic [COLOR_W+3:0]         c_sum;

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign seg_acc       = in_acc && (s_axis_tuser[1:0] == REQ_SEGMENT);
  assign out_free      = !m_valid_q || m_axis_tready;

  // request seen by the lanes
  always_comb begin
    req.accept   = in_acc;
    req.req_type = s_axis_tuser[1:0];
    req.comp     = s_axis_tdata[OFS_COMP +: COMP_W];
    req.index    = s_axis_tdata[OFS_INDEX +: INDEX_W];
    for (int j = 0; j < LANES_HW; j++) begin
      req.value[j] = s_axis_tdata[OFS_V0 + j*VALUE_W +: VALUE_W];
    end
  end

  // component lanes
  for (genvar g = 0; g < LANES_HW; g++) begin : g_lane
    if (g < MAX_COMPONENTS) begin : g_on
      rsc_lane #(
        .TABLE_SIZE(TABLE_SIZE),
        .LANE_ID   (g)
      ) u_lane (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .req_i (req),
        .data_o(lane_data[g])
      );
    end else begin : g_off
      assign lane_data[g] = '0;
    end
  end

  // component count limited to the lanes present
  always_comb begin
    if (count_q == 3'd0) n_eff = 3'd1;
    else if (count_q > 3'(MAX_COMPONENTS)) n_eff = 3'(MAX_COMPONENTS);
    else n_eff = count_q;
  end

  // merge start: lane 0 lookup or direct values
  assign init_col    = indep_q ? {lane_data[0].blue, lane_data[0].green, lane_data[0].red}
                               : dcol_q;
  assign init_tau    = indep_q ? TAU_W'(lane_data[0].att) : TAU_W'(dtau_q);
  assign mctrl.start = (state_q == ST_MERGE);
  assign mctrl.steps = indep_q ? COMP_W'(n_eff - 3'd1) : '0;

  rsc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mctrl),
    .init_col_i(init_col),
    .init_tau_i(init_tau),
    .lane_i    (lane_data),
    .busy_o    (merge_busy),
    .col_o     (mcol),
    .tau_o     (mtau)
  );

  rsc_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == ST_EXP),
    .x_i    (x_q),
    .busy_o (exp_busy),
    .e_o    (exp_e)
  );

  // optical depth and rounded exp result
  assign xprod = XP_W'(len_q) * XP_W'(mtau) + XP_W'(17'h08000);
  assign e_rnd = {1'b0, exp_e} + (E_W+1)'(17'h08000);

  // running color, cleared at ray start, and the saturating update
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      base[j] = ray_q ? '0 : acc_q[j];
    end
    c_rnd = '0;
    c_sum = '0;
    for (int j = 0; j < 3; j++) begin
      c_rnd    = {1'b0, cw_q[j]} + (CW_W+1)'(33'h080000000);
      c_sum    = (COLOR_W+4)'(base[j]) + (COLOR_W+4)'(c_rnd[CW_W:32]);
      acc_n[j] = (c_sum > (COLOR_W+4)'(COLOR_W'('1))) ? '1 : c_sum[COLOR_W-1:0];
    end
    o_rnd    = {1'b0, w_q} + (W_W+1)'(17'h08000);
    c_sum    = (COLOR_W+4)'(base[3]) + (COLOR_W+4)'(o_rnd[W_W:16]);
    acc_n[3] = (c_sum > (COLOR_W+4)'(COLOR_W'('1))) ? '1 : c_sum[COLOR_W-1:0];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      indep_q <= 1'b1;
      count_q <= 3'd1;
      four_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_INDEPENDENT: indep_q <= cfg_data_i[0];
        CFG_COUNT:       count_q <= cfg_data_i;
        CFG_FOUR_CH:     four_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // segment sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != ST_FIN)) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE:  if (seg_acc) state_q <= ST_IDX;
        ST_IDX:   state_q <= ST_READ;
        ST_READ:  state_q <= ST_MERGE;
        ST_MERGE: state_q <= ST_MWAIT;
        ST_MWAIT: if (!merge_busy) state_q <= ST_XMUL;
        ST_XMUL:  state_q <= ST_EXP;
        ST_EXP:   state_q <= ST_EWAIT;
        ST_EWAIT: if (!exp_busy) state_q <= ST_ALPHA;
        ST_ALPHA: state_q <= ST_WMUL;
        ST_WMUL:  state_q <= ST_CMUL;
        ST_CMUL:  state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            acc_q     <= acc_n;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // segment datapath
  always_ff @(posedge clk_i) begin
    if (seg_acc) begin
      len_q     <= s_axis_tdata[OFS_LEN +: LEN_W];
      ray_q     <= s_axis_tuser[2];
      if (four_q) begin
        for (int j = 0; j < 3; j++) begin
          dcol_q[j] <= clamp_color(req.value[j]);
        end
        dtau_q <= clamp_atten(req.value[3]);
      end else begin
        for (int j = 0; j < 3; j++) begin
          dcol_q[j] <= clamp_color(req.value[0]);
        end
        dtau_q <= clamp_atten(req.value[1]);
      end
    end
    if (state_q == ST_XMUL) x_q <= xprod[XP_W-1:16];
    if (state_q == ST_ALPHA) alpha_q <= A_W'((E_W+1)'(65536) - (E_W+1)'(e_rnd[E_W:16]));
    if (state_q == ST_WMUL) w_q <= W_W'(alpha_q) * W_W'(A_W'(65536) - A_W'(base[3]));
    if (state_q == ST_CMUL) begin
      for (int j = 0; j < 3; j++) begin
        cw_q[j] <= CW_W'(mcol[j]) * CW_W'(w_q);
      end
    end
    if (state_q == ST_FIN && out_free) out_q <= {acc_n[3], acc_n[2], acc_n[1], acc_n[0]};
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ design/rsc_checker.sv @@
// port level checks of the ray segment compositor, bound to the top level
module rsc_assertions import rsc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // a table, mapping or unknown transfer never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != REQ_SEGMENT))
    |=> s_axis_tready)
    else $error("input stalled after a write transfer");

  // a segment transfer occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == REQ_SEGMENT))
    |=> !s_axis_tready)
    else $error("input ready right after a segment transfer");

  // a new result appears only once the segment work is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result shown while a segment is still in work");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind ray_segment_compositor_top rsc_assertions u_rsc_assertions (.*);
